// ===== hw/rtl/keyed_object_table_defines.svh =====
// Assertion macros used by the checker file of the keyed object table.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef KEYED_OBJECT_TABLE_DEFINES_SVH
`define KEYED_OBJECT_TABLE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define KOT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define KOT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/kot_pkg.sv =====
`timescale 1ns / 1ps

package kot_pkg;

   // Default table depth.
   localparam int NUM_ENTRIES_DEF = 16;

   // Field widths of the request and response transfers.
   localparam int ACTION_W   = 3;
   localparam int SLOT_W     = 8;
   localparam int INDEX_W    = 16;
   localparam int SUBINDEX_W = 8;
   localparam int SIZE_W     = 4;
   localparam int PAYLOAD_W  = 64;
   localparam int STATUS_W   = 2;
   localparam int OUT_SLOT_W = 4;
   localparam int LOW_W      = 32;
   localparam int ENTRY_W    = INDEX_W + SUBINDEX_W + SIZE_W + PAYLOAD_W;

   // Action codes.
   localparam logic [ACTION_W-1:0] ACT_LOAD      = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_WRITE_KEY = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_WRITE_CUR = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_READ_KEY  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_READ_CUR  = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_ADV_READ  = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_ADV_WRITE = 3'd6;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OUT_OF_SYNC = 2'd2;

   // Stored sizes that a cursor write treats as a low-word object.
   localparam logic [SIZE_W-1:0] SIZE_BYTE = 4'd1;
   localparam logic [SIZE_W-1:0] SIZE_HALF = 4'd2;
   localparam logic [SIZE_W-1:0] SIZE_WORD = 4'd4;

   // One table entry as it sits in the RAM.
   typedef struct packed {
      logic [INDEX_W-1:0]    obj_index;
      logic [SUBINDEX_W-1:0] obj_subindex;
      logic [SIZE_W-1:0]     obj_size;
      logic [PAYLOAD_W-1:0]  payload;
   } entry_type;

   // A classified request waiting for the back end.
   typedef struct packed {
      logic [ACTION_W-1:0]   action;
      logic                  slot_ok;
      logic [SLOT_W-1:0]     slot;
      logic [INDEX_W-1:0]    obj_index;
      logic [SUBINDEX_W-1:0] obj_subindex;
      logic [SIZE_W-1:0]     obj_size;
      logic [PAYLOAD_W-1:0]  payload;
   } cmd_type;

   // Mask covering the low nbytes bytes; eight or more covers the whole word.
   function automatic logic [PAYLOAD_W-1:0] byte_mask(input logic [SIZE_W-1:0] nbytes);
      logic [PAYLOAD_W-1:0] m;
      m = '0;
      for (int b = 0; b < PAYLOAD_W / 8; b++) begin
         if (SIZE_W'(b) < nbytes) begin
            m[b*8 +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

endpackage

// ===== hw/rtl/kot_if.sv =====
`timescale 1ns / 1ps

// Request channel: one action per transfer.
interface kot_req_if;
   import kot_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [ACTION_W-1:0]   action;
   logic [SLOT_W-1:0]     slot;
   logic [INDEX_W-1:0]    obj_index;
   logic [SUBINDEX_W-1:0] obj_subindex;
   logic [SIZE_W-1:0]     obj_size;
   logic [PAYLOAD_W-1:0]  payload;

   modport source (
      output valid, action, slot, obj_index, obj_subindex, obj_size, payload,
      input  ready
   );
   modport sink (
      input  valid, action, slot, obj_index, obj_subindex, obj_size, payload,
      output ready
   );
endinterface

// Response channel: one result per request.
interface kot_rsp_if;
   import kot_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [OUT_SLOT_W-1:0] out_slot;
   logic [INDEX_W-1:0]    out_index;
   logic [SUBINDEX_W-1:0] out_subindex;
   logic [SIZE_W-1:0]     out_size;
   logic [PAYLOAD_W-1:0]  out_payload;

   modport source (
      output valid, status, out_slot, out_index, out_subindex, out_size, out_payload,
      input  ready
   );
   modport sink (
      input  valid, status, out_slot, out_index, out_subindex, out_size, out_payload,
      output ready
   );
endinterface

// ===== hw/rtl/kot_ram.sv =====
`timescale 1ns / 1ps

module kot_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one read port with registered data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/kot_front.sv =====
`timescale 1ns / 1ps

module kot_front #(
   parameter int NUM_ENTRIES = kot_pkg::NUM_ENTRIES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   kot_req_if.sink          req_bus,
   output kot_pkg::cmd_type cmd,
   output logic             cmd_valid,
   input  logic             cmd_pop
);
   import kot_pkg::*;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   cmd_type             q_ff [QDEPTH];
   cmd_type             new_cmd;
   logic [QPTR_W-1:0]   head_ff, head_in;
   logic [QPTR_W-1:0]   tail_ff, tail_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push;
   logic                pop;

   // Classify the incoming request; a load checks its slot against the depth here.
   always_comb begin
      new_cmd.action       = req_bus.action;
      new_cmd.slot_ok      = {1'b0, req_bus.slot} < (SLOT_W + 1)'(NUM_ENTRIES);
      new_cmd.slot         = req_bus.slot;
      new_cmd.obj_index    = req_bus.obj_index;
      new_cmd.obj_subindex = req_bus.obj_subindex;
      new_cmd.obj_size     = req_bus.obj_size;
      new_cmd.payload      = req_bus.payload;
   end

   assign req_bus.ready = count_ff != QCNT_W'(QDEPTH);
   assign push          = req_bus.valid && req_bus.ready;
   assign pop           = cmd_pop && (count_ff != '0);

   // Queue pointers and fill level.
   always_comb begin
      head_in  = pop  ? head_ff + 1'b1 : head_ff;
      tail_in  = push ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[tail_ff] <= new_cmd;
      end
   end

   assign cmd       = q_ff[head_ff];
   assign cmd_valid = count_ff != '0;

endmodule

// ===== hw/rtl/kot_back.sv =====
`timescale 1ns / 1ps

module kot_back #(
   parameter int NUM_ENTRIES = kot_pkg::NUM_ENTRIES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  kot_pkg::cmd_type cmd,
   input  logic             cmd_valid,
   output logic             cmd_pop,
   kot_rsp_if.source        rsp_bus
);
   import kot_pkg::*;

   localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam logic [AW-1:0] LAST = AW'(NUM_ENTRIES - 1);

   localparam logic S_IDLE  = 1'b0;
   localparam logic S_CHECK = 1'b1;

   logic                     state_ff, state_in;
   cmd_type                  cmd_ff, cmd_in;
   logic [AW-1:0]            scan_ff, scan_in;
   logic [AW-1:0]            rd_cur_ff, rd_cur_in;
   logic [AW-1:0]            wr_cur_ff, wr_cur_in;
   logic [NUM_ENTRIES-1:0]   valid_ff, valid_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [OUT_SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   entry_type                rsp_entry_ff, rsp_entry_in;

   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   entry_type                wr_data;
   logic [ENTRY_W-1:0]       rd_word;
   entry_type                entry;
   logic [AW-1:0]            load_addr;
   logic                     out_free;
   logic                     key_hit;
   logic                     size_hit;
   logic [PAYLOAD_W-1:0]     key_mask;
   logic [PAYLOAD_W-1:0]     cur_mask;
   logic [PAYLOAD_W-1:0]     key_payload;
   logic [PAYLOAD_W-1:0]     cur_payload;

   kot_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (scan_in),
      .rd_data (rd_word)
   );

   // An entry never written reads as the cleared value.
   assign entry     = valid_ff[scan_ff] ? entry_type'(rd_word) : '0;
   assign load_addr = AW'(cmd.slot);
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign key_hit   = (entry.obj_index == cmd_ff.obj_index) &&
                      (entry.obj_subindex == cmd_ff.obj_subindex);
   assign size_hit  = entry.obj_size == cmd_ff.obj_size;

   // Payload merges for the two write actions.
   always_comb begin
      key_mask    = byte_mask(cmd_ff.obj_size);
      cur_mask    = byte_mask(entry.obj_size);
      key_payload = (entry.payload & ~key_mask) | (cmd_ff.payload & key_mask);
      if ((entry.obj_size == SIZE_BYTE) || (entry.obj_size == SIZE_HALF) ||
          (entry.obj_size == SIZE_WORD)) begin
         cur_payload = {entry.payload[PAYLOAD_W-1:LOW_W],
                        cmd_ff.payload[LOW_W-1:0] & cur_mask[LOW_W-1:0]};
      end else begin
         cur_payload = cmd_ff.payload;
      end
   end

   // Sequencer: immediate actions finish in the idle state, the others read the table.
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      scan_in       = scan_ff;
      rd_cur_in     = rd_cur_ff;
      wr_cur_in     = wr_cur_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_entry_in  = rsp_entry_ff;
      cmd_pop       = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = scan_ff;
      wr_data       = entry;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop       = 1'b1;
               cmd_in        = cmd;
               rsp_entry_in  = '0;
               rsp_slot_in   = '0;
               rsp_status_in = ST_NOT_FOUND;
               unique case (cmd.action) inside
                  ACT_LOAD: begin
                     rsp_valid_in = 1'b1;
                     if (cmd.slot_ok) begin
                        wr_en                = 1'b1;
                        wr_addr              = load_addr;
                        wr_data.obj_index    = cmd.obj_index;
                        wr_data.obj_subindex = cmd.obj_subindex;
                        wr_data.obj_size     = cmd.obj_size;
                        wr_data.payload      = cmd.payload;
                        valid_in[load_addr]  = 1'b1;
                        rsp_status_in        = ST_OK;
                        rsp_slot_in          = OUT_SLOT_W'(load_addr);
                     end
                  end
                  ACT_WRITE_KEY, ACT_READ_KEY: begin
                     scan_in  = '0;
                     state_in = S_CHECK;
                  end
                  ACT_WRITE_CUR: begin
                     scan_in  = wr_cur_ff;
                     state_in = S_CHECK;
                  end
                  ACT_READ_CUR: begin
                     scan_in  = rd_cur_ff;
                     state_in = S_CHECK;
                  end
                  ACT_ADV_READ: begin
                     rd_cur_in     = (rd_cur_ff == LAST) ? '0 : rd_cur_ff + 1'b1;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_OK;
                     rsp_slot_in   = OUT_SLOT_W'(rd_cur_in);
                  end
                  ACT_ADV_WRITE: begin
                     wr_cur_in     = (wr_cur_ff == LAST) ? '0 : wr_cur_ff + 1'b1;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_OK;
                     rsp_slot_in   = OUT_SLOT_W'(wr_cur_in);
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_CHECK: begin
            // The response register is empty here: it was free when the item was taken.
            rsp_entry_in  = '0;
            rsp_slot_in   = '0;
            rsp_status_in = ST_NOT_FOUND;
            unique case (cmd_ff.action) inside
               ACT_READ_CUR: begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_OK;
                  rsp_slot_in   = OUT_SLOT_W'(scan_ff);
                  rsp_entry_in  = entry;
                  state_in      = S_IDLE;
               end
               ACT_WRITE_CUR: begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
                  if (key_hit) begin
                     wr_en                = 1'b1;
                     wr_data.payload      = cur_payload;
                     valid_in[scan_ff]    = 1'b1;
                     rsp_status_in        = ST_OK;
                     rsp_slot_in          = OUT_SLOT_W'(scan_ff);
                  end else begin
                     rsp_status_in = ST_OUT_OF_SYNC;
                  end
               end
               ACT_WRITE_KEY: begin
                  if (key_hit && size_hit) begin
                     wr_en             = 1'b1;
                     wr_data.payload   = key_payload;
                     valid_in[scan_ff] = 1'b1;
                     rsp_valid_in      = 1'b1;
                     rsp_status_in     = ST_OK;
                     rsp_slot_in       = OUT_SLOT_W'(scan_ff);
                     state_in          = S_IDLE;
                  end else if (scan_ff == LAST) begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     scan_in = scan_ff + 1'b1;
                  end
               end
               ACT_READ_KEY: begin
                  if (key_hit) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_OK;
                     rsp_slot_in   = OUT_SLOT_W'(scan_ff);
                     rsp_entry_in  = entry;
                     state_in      = S_IDLE;
                  end else if (scan_ff == LAST) begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     scan_in = scan_ff + 1'b1;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scan_ff      <= '0;
         rd_cur_ff    <= '0;
         wr_cur_ff    <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         rd_cur_ff    <= rd_cur_in;
         wr_cur_ff    <= wr_cur_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Command and response payload.
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_entry_ff  <= rsp_entry_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.out_slot     = rsp_slot_ff;
   assign rsp_bus.out_index    = rsp_entry_ff.obj_index;
   assign rsp_bus.out_subindex = rsp_entry_ff.obj_subindex;
   assign rsp_bus.out_size     = rsp_entry_ff.obj_size;
   assign rsp_bus.out_payload  = rsp_entry_ff.payload;

endmodule

// ===== hw/rtl/keyed_object_table.sv =====
`timescale 1ns / 1ps

// Keyed object table: NUM_ENTRIES entries of index, subindex, size and payload,
// with a read cursor and a write cursor that wrap at the table depth.
// req_bus carries one action per transfer; rsp_bus returns exactly one result per
// request, in request order. Both channels use valid/ready.
// A front end classifies requests into a two-entry queue; a back end sequences
// them against a table RAM with one write port, one read port and registered
// read data. Load, cursor advance and unused codes finish in the idle state;
// a read or write at a cursor reads the entry at that cursor; a key read or key
// write scans the table one entry per cycle through the RAM read port and stops
// at the first match. The queue takes new requests while the back end is still
// busy with an earlier one.
// Reset (synchronous) clears both cursors, all entry valid bits (so the whole
// table reads as zero) and both channel states. No clearing pass is needed.
// When the receiver holds rsp_bus.ready low, the response stays registered and
// stable, the back end stops, and the queue fills until req_bus.ready drops.
module keyed_object_table #(
   parameter int NUM_ENTRIES = kot_pkg::NUM_ENTRIES_DEF
) (
   input logic       clock,
   input logic       reset,
   kot_req_if.sink   req_bus,
   kot_rsp_if.source rsp_bus
);
   import kot_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;

   // Request intake and classification.
   kot_front #(
      .NUM_ENTRIES (NUM_ENTRIES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop)
   );

   // Table access and response.
   kot_back #(
      .NUM_ENTRIES (NUM_ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ===== hw/rtl/kot_checker.sv =====
`timescale 1ns / 1ps
`include "keyed_object_table_defines.svh"

module kot_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [kot_pkg::STATUS_W-1:0]   rsp_status,
   input logic [kot_pkg::OUT_SLOT_W-1:0] rsp_out_slot,
   input logic [kot_pkg::INDEX_W-1:0]    rsp_out_index,
   input logic [kot_pkg::SUBINDEX_W-1:0] rsp_out_subindex,
   input logic [kot_pkg::SIZE_W-1:0]     rsp_out_size,
   input logic [kot_pkg::PAYLOAD_W-1:0]  rsp_out_payload
);
   import kot_pkg::*;

   // A failed action returns no slot and no entry data.
   `KOT_ASSERT_NOW(a_fail_clean, rsp_valid && (rsp_status != ST_OK), (rsp_out_slot == '0) && (rsp_out_index == '0) && (rsp_out_subindex == '0) && (rsp_out_size == '0) && (rsp_out_payload == '0), "failed response carries data")

   // Only the three defined status codes appear.
   `KOT_ASSERT_NOW(a_status_code, rsp_valid, (rsp_status == ST_OK) || (rsp_status == ST_NOT_FOUND) || (rsp_status == ST_OUT_OF_SYNC), "undefined status code")

   // A stalled response stays valid and keeps its status, slot and payload.
   `KOT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_out_slot) && $stable(rsp_out_payload), "stalled response changed")

endmodule

bind keyed_object_table kot_checker u_kot_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_status       (rsp_bus.status),
   .rsp_out_slot     (rsp_bus.out_slot),
   .rsp_out_index    (rsp_bus.out_index),
   .rsp_out_subindex (rsp_bus.out_subindex),
   .rsp_out_size     (rsp_bus.out_size),
   .rsp_out_payload  (rsp_bus.out_payload)
);

// ===== tb/keyed_object_table_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the keyed object table, keeps its own copy of the
// table and cursors, and compares every response transfer with the oldest
// predicted result.
module keyed_object_table_checker #(
   parameter int NUM_ENTRIES = kot_pkg::NUM_ENTRIES_DEF
) (
   input  logic clock,
   input  logic reset,
   kot_req_if   req_bus,
   kot_rsp_if   rsp_bus,
   output int   error_count,
   output int   pending_count
);
   import kot_pkg::*;

   // One response as it appears on the result channel.
   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [OUT_SLOT_W-1:0] out_slot;
      logic [INDEX_W-1:0]    out_index;
      logic [SUBINDEX_W-1:0] out_subindex;
      logic [SIZE_W-1:0]     out_size;
      logic [PAYLOAD_W-1:0]  out_payload;
   } result_type;

   entry_type  entries [NUM_ENTRIES];
   int         read_pos;
   int         write_pos;
   result_type expected_results [$];
   int         fail_total = 0;
   int         waiting = 0;

   assign error_count   = fail_total;
   assign pending_count = waiting;

   // Mask over the low n bytes; eight or more bytes cover the whole payload.
   function automatic logic [PAYLOAD_W-1:0] low_bytes(input logic [SIZE_W-1:0] n);
      if (n >= 8) begin
         return '1;
      end
      return (64'd1 << (8 * n)) - 64'd1;
   endfunction

   // A successful read returns the whole entry and its position.
   function automatic result_type entry_result(input int pos);
      result_type r;
      r              = '0;
      r.status       = ST_OK;
      r.out_slot     = OUT_SLOT_W'(pos);
      r.out_index    = entries[pos].obj_index;
      r.out_subindex = entries[pos].obj_subindex;
      r.out_size     = entries[pos].obj_size;
      r.out_payload  = entries[pos].payload;
      return r;
   endfunction

   // Applies one request to the table copy and returns the result it gives.
   function automatic result_type apply_request(
      input logic [ACTION_W-1:0]   action,
      input logic [SLOT_W-1:0]     slot,
      input logic [INDEX_W-1:0]    idx,
      input logic [SUBINDEX_W-1:0] sub,
      input logic [SIZE_W-1:0]     size,
      input logic [PAYLOAD_W-1:0]  pay
   );
      result_type           r;
      int                   hit;
      logic [SIZE_W-1:0]    stored;
      logic [PAYLOAD_W-1:0] m;
      r        = '0;
      r.status = ST_NOT_FOUND;
      hit      = -1;
      case (action)
         ACT_LOAD: begin
            if (slot < NUM_ENTRIES) begin
               entries[slot].obj_index    = idx;
               entries[slot].obj_subindex = sub;
               entries[slot].obj_size     = size;
               entries[slot].payload      = pay;
               r.status   = ST_OK;
               r.out_slot = slot[OUT_SLOT_W-1:0];
            end
         end
         ACT_WRITE_KEY: begin
            // Scan downward so the lowest matching slot is the one kept.
            for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
               if (entries[i].obj_index == idx && entries[i].obj_subindex == sub &&
                   entries[i].obj_size == size) begin
                  hit = i;
               end
            end
            if (hit >= 0) begin
               m = low_bytes(size);
               entries[hit].payload = (entries[hit].payload & ~m) | (pay & m);
               r.status   = ST_OK;
               r.out_slot = OUT_SLOT_W'(hit);
            end
         end
         ACT_WRITE_CUR: begin
            if (entries[write_pos].obj_index == idx &&
                entries[write_pos].obj_subindex == sub) begin
               stored = entries[write_pos].obj_size;
               // Small objects live in the low word, zero-extended; the high word stays.
               if (stored == SIZE_BYTE || stored == SIZE_HALF || stored == SIZE_WORD) begin
                  entries[write_pos].payload[LOW_W-1:0] = LOW_W'(pay & low_bytes(stored));
               end else begin
                  entries[write_pos].payload = pay;
               end
               r.status   = ST_OK;
               r.out_slot = OUT_SLOT_W'(write_pos);
            end else begin
               r.status = ST_OUT_OF_SYNC;
            end
         end
         ACT_READ_KEY: begin
            for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
               if (entries[i].obj_index == idx && entries[i].obj_subindex == sub) begin
                  hit = i;
               end
            end
            if (hit >= 0) begin
               r = entry_result(hit);
            end
         end
         ACT_READ_CUR: begin
            r = entry_result(read_pos);
         end
         ACT_ADV_READ: begin
            read_pos   = (read_pos + 1) % NUM_ENTRIES;
            r.status   = ST_OK;
            r.out_slot = OUT_SLOT_W'(read_pos);
         end
         ACT_ADV_WRITE: begin
            write_pos  = (write_pos + 1) % NUM_ENTRIES;
            r.status   = ST_OK;
            r.out_slot = OUT_SLOT_W'(write_pos);
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // Counts a failure and prints the first few in full.
   task automatic report_failure(input string what, input result_type want,
                                 input result_type got);
      fail_total++;
      if (fail_total <= 10) begin
         $display("%0t ns: %s: expected status %0d slot %0d index %h subindex %h size %0d",
                  $time, what, want.status, want.out_slot, want.out_index,
                  want.out_subindex, want.out_size);
         $display("   payload %h; got status %0d slot %0d index %h subindex %h size %0d",
                  want.out_payload, got.status, got.out_slot, got.out_index,
                  got.out_subindex, got.out_size);
         $display("   payload %h", got.out_payload);
      end
   endtask

   // Responses are matched before requests are predicted; a response can never
   // belong to a request that transfers at the same edge.
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            entries[i] = '0;
         end
         read_pos  = 0;
         write_pos = 0;
         expected_results.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.status       = rsp_bus.status;
            got.out_slot     = rsp_bus.out_slot;
            got.out_index    = rsp_bus.out_index;
            got.out_subindex = rsp_bus.out_subindex;
            got.out_size     = rsp_bus.out_size;
            got.out_payload  = rsp_bus.out_payload;
            if (expected_results.size() == 0) begin
               report_failure("response with no request outstanding", '0, got);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  report_failure("response mismatch", want, got);
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            expected_results.push_back(apply_request(req_bus.action, req_bus.slot,
               req_bus.obj_index, req_bus.obj_subindex, req_bus.obj_size, req_bus.payload));
         end
      end
      waiting = expected_results.size();
   end

endmodule

// ===== tb/keyed_object_table_test.sv =====
`timescale 1ns / 1ps

// Drives requests into the keyed object table and stalls its response channel;
// the checker beside the block predicts and compares every response.
module keyed_object_table_test;
   import kot_pkg::*;

   localparam int TABLE_DEPTH     = NUM_ENTRIES_DEF;
   localparam int ITEMS_PER_PHASE = 600;
   localparam logic [PAYLOAD_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   error_count;
   int   pending_count;

   // Keys loaded into each slot, so random requests can aim at live entries.
   logic [INDEX_W-1:0]    slot_index    [TABLE_DEPTH];
   logic [SUBINDEX_W-1:0] slot_subindex [TABLE_DEPTH];
   logic [SIZE_W-1:0]     slot_size     [TABLE_DEPTH];
   int                    write_pos;

   kot_req_if req_bus ();
   kot_rsp_if rsp_bus ();

   keyed_object_table #(
      .NUM_ENTRIES(TABLE_DEPTH)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   keyed_object_table_checker #(
      .NUM_ENTRIES(TABLE_DEPTH)
   ) i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .error_count  (error_count),
      .pending_count(pending_count)
   );

   always #2 clock = ~clock;

   // The receiver stalls at random at the current rate.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offers one request after a random gap and holds it until the transfer.
   // Ready is sampled at the falling edge, where it is settled.
   task automatic send_item(
      input logic [ACTION_W-1:0]   action,
      input logic [SLOT_W-1:0]     slot,
      input logic [INDEX_W-1:0]    idx,
      input logic [SUBINDEX_W-1:0] sub,
      input logic [SIZE_W-1:0]     size,
      input logic [PAYLOAD_W-1:0]  pay
   );
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.action       <= action;
      req_bus.slot         <= slot;
      req_bus.obj_index    <= idx;
      req_bus.obj_subindex <= sub;
      req_bus.obj_size     <= size;
      req_bus.payload      <= pay;
      do begin
         @(negedge clock);
         taken = req_bus.ready;
         @(posedge clock);
      end while (!taken);
      if (action == ACT_LOAD && slot < TABLE_DEPTH) begin
         slot_index[slot]    = idx;
         slot_subindex[slot] = sub;
         slot_size[slot]     = size;
      end
      if (action == ACT_ADV_WRITE) begin
         write_pos = (write_pos + 1) % TABLE_DEPTH;
      end
   endtask

   // Mostly requests aimed at live keys, with some noise from a small key pool.
   task automatic random_item();
      logic [ACTION_W-1:0]   action;
      logic [SLOT_W-1:0]     slot;
      logic [INDEX_W-1:0]    idx;
      logic [SUBINDEX_W-1:0] sub;
      logic [SIZE_W-1:0]     size;
      int                    aim;
      action = ACTION_W'($urandom_range(ACT_ADV_WRITE));
      if ($urandom_range(9) == 0) begin
         slot = SLOT_W'($urandom);
      end else begin
         slot = SLOT_W'($urandom_range(TABLE_DEPTH - 1));
      end
      aim = (action == ACT_WRITE_CUR) ? write_pos : $urandom_range(TABLE_DEPTH - 1);
      if (action != ACT_LOAD && $urandom_range(4) != 0) begin
         idx  = slot_index[aim];
         sub  = slot_subindex[aim];
         size = slot_size[aim];
      end else begin
         case ($urandom_range(3))
            0: idx = '0;
            1: idx = '1;
            2: idx = 16'h5A3C;
            default: idx = INDEX_W'($urandom);
         endcase
         case ($urandom_range(3))
            0: sub = '0;
            1: sub = '1;
            2: sub = 8'h81;
            default: sub = SUBINDEX_W'($urandom);
         endcase
         size = SIZE_W'($urandom_range(8));
      end
      send_item(action, slot, idx, sub, size, {$urandom, $urandom});
   endtask

   initial begin
      req_bus.valid        = 1'b0;
      req_bus.action       = ACT_LOAD;
      req_bus.slot         = '0;
      req_bus.obj_index    = '0;
      req_bus.obj_subindex = '0;
      req_bus.obj_size     = '0;
      req_bus.payload      = '0;
      send_idle_pct        = 25;
      recv_idle_pct        = 71;
      write_pos            = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         slot_index[i]    = '0;
         slot_subindex[i] = '0;
         slot_size[i]     = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Accesses to the cleared table, then loads in and out of range.
      send_item(ACT_READ_CUR, 8'd0, 16'h0000, 8'h00, 4'd0, '0);
      send_item(ACT_READ_KEY, 8'd0, 16'h0000, 8'h00, 4'd0, '0);
      send_item(ACT_WRITE_KEY, 8'd0, 16'h0000, 8'h00, 4'd0, ALL_ONES);
      send_item(ACT_LOAD, 8'd255, 16'hFFFF, 8'hFF, 4'd8, ALL_ONES);
      send_item(ACT_LOAD, 8'd16, 16'hFFFF, 8'hFF, 4'd8, ALL_ONES);
      send_item(ACT_LOAD, 8'd15, 16'hFFFF, 8'hFF, 4'd8, ALL_ONES);
      send_item(ACT_WRITE_KEY, 8'd0, 16'hFFFF, 8'hFF, 4'd8, 64'h0123_4567_89AB_CDEF);
      send_item(ACT_READ_KEY, 8'd0, 16'hFFFF, 8'hFF, 4'd0, '0);

      // Two entries share a key with different sizes; size picks the slot.
      send_item(ACT_LOAD, 8'd3, 16'h1234, 8'h05, 4'd4, ALL_ONES);
      send_item(ACT_LOAD, 8'd7, 16'h1234, 8'h05, 4'd2, ALL_ONES);
      send_item(ACT_WRITE_KEY, 8'd0, 16'h1234, 8'h05, 4'd2, '0);
      send_item(ACT_WRITE_KEY, 8'd0, 16'h1234, 8'h05, 4'd4, '0);
      send_item(ACT_WRITE_KEY, 8'd0, 16'h1234, 8'h05, 4'd3, '0);
      send_item(ACT_READ_KEY, 8'd0, 16'h1234, 8'h05, 4'd0, '0);
      send_item(ACT_READ_KEY, 8'd0, 16'h4321, 8'h09, 4'd0, '0);

      // Cursor writes: a key mismatch, a full replace, and a one-byte object.
      send_item(ACT_WRITE_CUR, 8'd0, 16'h1234, 8'h05, 4'd0, '0);
      send_item(ACT_WRITE_CUR, 8'd0, 16'h0000, 8'h00, 4'd0, ALL_ONES);
      send_item(ACT_LOAD, 8'd1, 16'hABCD, 8'h00, 4'd1, ALL_ONES);
      send_item(ACT_ADV_WRITE, 8'd0, 16'h0000, 8'h00, 4'd0, '0);
      send_item(ACT_WRITE_CUR, 8'd0, 16'hABCD, 8'h00, 4'd0, 64'h0000_0000_0000_A55A);
      send_item(ACT_ADV_READ, 8'd0, 16'h0000, 8'h00, 4'd0, '0);
      send_item(ACT_READ_CUR, 8'd0, 16'h0000, 8'h00, 4'd0, '0);

      // Random traffic under three idling patterns.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 25;
               recv_idle_pct = 71;
            end
            1: begin
               send_idle_pct = 71;
               recv_idle_pct = 25;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         repeat (ITEMS_PER_PHASE) random_item();
      end
      req_bus.valid <= 1'b0;

      // Drain the outstanding responses, then watch for stray ones.
      @(negedge clock);
      while (pending_count != 0) begin
         @(negedge clock);
      end
      repeat (40) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("keyed_object_table_test: clean");
      end else begin
         $display("keyed_object_table_test: errors");
      end
      $finish;
   end

   // Hard stop well beyond the slowest correct run.
   initial begin
      #5000000;
      $display("keyed_object_table_test: errors");
      $finish;
   end

endmodule

// ===== keyed_object_table.f =====
+incdir+hw/rtl
hw/rtl/kot_pkg.sv
hw/rtl/kot_if.sv
hw/rtl/kot_ram.sv
hw/rtl/kot_front.sv
hw/rtl/kot_back.sv
hw/rtl/keyed_object_table.sv
hw/rtl/kot_checker.sv
tb/keyed_object_table_checker.sv
tb/keyed_object_table_test.sv
